@@ sv/color_to_palette_index_cache_assert.svh @@
`ifndef COLOR_TO_PALETTE_INDEX_CACHE_ASSERT_SVH
`define COLOR_TO_PALETTE_INDEX_CACHE_ASSERT_SVH

// property checked in the cycle after the trigger
`define CPIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cpic assertion failed");

// property checked in the same cycle as the trigger
`define CPIC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cpic assertion failed");

`endif

@@ sv/cpic_pkg.sv @@
package cpic_pkg;

    localparam int CACHE_ENTRIES = 32;
    localparam int PTR_W         = $clog2(CACHE_ENTRIES);
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
    localparam int COLOR_W       = 24;
    localparam int PAL_W         = 32;
    localparam int IDX_W         = 8;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    typedef struct packed {
        logic load;
        logic match;
        logic fill;
        logic read;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_fill;
        logic out_free;
    } t_dp_sts;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CACHE_ENTRIES - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

@@ sv/cpic_ifs.sv @@
interface cpic_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [cpic_pkg::PAL_W-1:0]        palette_id;
    logic [cpic_pkg::COLOR_W-1:0]      color;
    logic [cpic_pkg::IDX_W-1:0]        fill_index;

    modport source(output valid, cmd, palette_id, color, fill_index, input ready);
    modport sink(input valid, cmd, palette_id, color, fill_index, output ready);
endinterface

interface cpic_out_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [cpic_pkg::IDX_W-1:0]        pal_index;

    modport source(output valid, hit, pal_index, input ready);
    modport sink(input valid, hit, pal_index, output ready);
endinterface

@@ sv/color_to_palette_index_cache.sv @@
// Fully associative cache from a 24-bit color to an 8-bit palette index, 32 entries.
// Each input transaction is a lookup (cmd 0) or a fill (cmd 1) and gives exactly one
// result transaction. A new palette_id, or the first transaction after reset, empties
// the cache first. A lookup returns the lowest matching entry with hit=1, or hit=0 and
// index 0 on a miss; a miss is served by finding the nearest color outside and sending
// a fill, which stores color and index at the replace pointer and echoes the index with
// hit=0. Transactions are handled one at a time: a lookup passes through parallel compare
// of all entries, priority encode and index memory read, and output load; a fill through
// entry write and output load. The next transaction is taken the cycle after the result
// is loaded, even if that result still waits for o_out.ready, so no new transaction is
// accepted before the previous one is through, and the output load waits while a previous
// result stalls.
module color_to_palette_index_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cpic_in_if.sink     i_in,
    cpic_out_if.source  o_out
);

    cpic_pkg::t_dp_cmd dp_cmd;
    cpic_pkg::t_dp_sts dp_sts;

    cpic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    cpic_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cmd_bit    (i_in.cmd),
        .i_palette_id (i_in.palette_id),
        .i_color      (i_in.color),
        .i_fill_index (i_in.fill_index),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_hit        (o_out.hit),
        .o_pal_index  (o_out.pal_index)
    );

endmodule

@@ sv/cpic_ctrl.sv @@
module cpic_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cpic_pkg::t_dp_sts i_sts,
    output cpic_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = i_sts.is_fill ? S_DONE : S_READ;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.match     = (r_state == S_MATCH) && !i_sts.is_fill;
    assign o_cmd.fill      = (r_state == S_MATCH) && i_sts.is_fill;
    assign o_cmd.read      = (r_state == S_READ);
    assign o_cmd.out_load  = (r_state == S_DONE) && i_sts.out_free;

endmodule

@@ sv/cpic_dp.sv @@
module cpic_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cpic_pkg::t_dp_cmd               i_cmd,
    output cpic_pkg::t_dp_sts               o_sts,
    input  logic                            i_cmd_bit,
    input  logic [cpic_pkg::PAL_W-1:0]      i_palette_id,
    input  logic [cpic_pkg::COLOR_W-1:0]    i_color,
    input  logic [cpic_pkg::IDX_W-1:0]      i_fill_index,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_hit,
    output logic [cpic_pkg::IDX_W-1:0]      o_pal_index
);

    localparam int N = cpic_pkg::CACHE_ENTRIES;

    logic                            r_cmd;
    logic [cpic_pkg::COLOR_W-1:0]    r_color;
    logic [cpic_pkg::IDX_W-1:0]      r_fidx;

    logic                            r_ever;
    logic [cpic_pkg::PAL_W-1:0]      r_cur;
    logic [cpic_pkg::CNT_W-1:0]      r_cnt;
    logic [cpic_pkg::PTR_W-1:0]      r_ptr;

    logic [cpic_pkg::COLOR_W-1:0]    r_entry_color [N];
    logic [cpic_pkg::IDX_W-1:0]      r_idx_mem [N];

    logic [N-1:0]                    r_match;
    logic [N-1:0]                    n_match;
    logic [cpic_pkg::PTR_W-1:0]      enc_idx;
    logic                            r_hit;
    logic [cpic_pkg::IDX_W-1:0]      r_rd_data;

    logic                            r_out_valid;
    logic                            r_out_hit;
    logic [cpic_pkg::IDX_W-1:0]      r_out_idx;

    logic                            flush;

    assign flush = !r_ever || (i_palette_id != r_cur);

    // per-entry compare, masked by valid count
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_match[i] = (r_entry_color[i] == r_color) && (cpic_pkg::CNT_W'(i) < r_cnt);
        end
    end

    // lowest matching entry
    always_comb begin
        enc_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                enc_idx = cpic_pkg::PTR_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_cmd_bit;
            r_color <= i_color;
            r_fidx  <= i_fill_index;
        end
        if (i_cmd.match) begin
            r_match <= n_match;
        end
        if (i_cmd.fill) begin
            r_entry_color[r_ptr] <= r_color;
            r_idx_mem[r_ptr]     <= r_fidx;
        end
        if (i_cmd.read) begin
            r_hit     <= |r_match;
            r_rd_data <= r_idx_mem[enc_idx];
        end
        if (i_cmd.out_load) begin
            if (r_cmd == cpic_pkg::CMD_FILL) begin
                r_out_hit <= 1'b0;
                r_out_idx <= r_fidx;
            end else begin
                r_out_hit <= r_hit;
                r_out_idx <= r_hit ? r_rd_data : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ever      <= 1'b0;
            r_cur       <= '0;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && flush) begin
                r_ever <= 1'b1;
                r_cur  <= i_palette_id;
                r_cnt  <= '0;
                r_ptr  <= '0;
            end
            if (i_cmd.fill) begin
                if (r_cnt != cpic_pkg::CNT_W'(N)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                r_ptr <= cpic_pkg::next_slot(r_ptr);
            end
            // hit under the replace pointer skips it
            if (i_cmd.read && (|r_match) && (enc_idx == r_ptr)) begin
                r_ptr <= cpic_pkg::next_slot(r_ptr);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.is_fill  = (r_cmd == cpic_pkg::CMD_FILL);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_pal_index    = r_out_idx;

endmodule

@@ sv/cpic_chk.sv @@
`include "color_to_palette_index_cache_assert.svh"

module cpic_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_hit,
    input logic [cpic_pkg::IDX_W-1:0]     i_out_pal_index
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // stalled result holds
    `CPIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid)
    `CPIC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(i_out_hit) && $stable(i_out_pal_index))
    // one transaction in flight at a time
    `CPIC_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, in_acc, !i_in_ready)
    // no result appears right after acceptance
    `CPIC_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, in_acc, !$rose(i_out_valid))

endmodule

bind color_to_palette_index_cache cpic_chk u_cpic_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_hit       (o_out.hit),
    .i_out_pal_index (o_out.pal_index)
);

@@ bench/color_to_palette_index_cache_checker.sv @@
`timescale 1ns / 100ps

module color_to_palette_index_cache_checker
    import cpic_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cpic_in_if   i_in_mon,
    cpic_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] pal_index;
    } t_reply;

    logic [COLOR_W-1:0] cached_color [CACHE_ENTRIES];
    logic [IDX_W-1:0]   cached_index [CACHE_ENTRIES];
    logic [CNT_W-1:0]   fill_level;
    logic [PTR_W-1:0]   victim_ptr;
    logic [PAL_W-1:0]   active_palette;
    logic               warmed;

    t_reply expected_replies[$];
    t_reply want;
    t_reply predicted;
    int     mismatches;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CACHE_ENTRIES - 1)) ? '0 : PTR_W'(p + 1);
    endfunction

    function automatic t_reply cache_response(
        input logic             cmd,
        input logic [PAL_W-1:0] pal,
        input logic [COLOR_W-1:0] col,
        input logic [IDX_W-1:0] fidx
    );
        t_reply r;
        logic   found;
        r     = '0;
        found = 1'b0;
        // flush on new palette or first transaction after reset
        if (!warmed || pal != active_palette) begin
            fill_level     = '0;
            victim_ptr     = '0;
            active_palette = pal;
            warmed         = 1'b1;
        end
        if (cmd == CMD_LOOKUP) begin
            for (int k = 0; k < CACHE_ENTRIES; k++) begin
                if (!found && k < fill_level && cached_color[k] == col) begin
                    found       = 1'b1;
                    r.hit       = 1'b1;
                    r.pal_index = cached_index[k];
                    if (PTR_W'(k) == victim_ptr) begin
                        victim_ptr = step_ptr(victim_ptr);
                    end
                end
            end
        end else begin
            cached_color[victim_ptr] = col;
            cached_index[victim_ptr] = fidx;
            if (fill_level < CNT_W'(CACHE_ENTRIES)) begin
                fill_level = fill_level + 1'b1;
            end
            victim_ptr  = step_ptr(victim_ptr);
            r.pal_index = fidx;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_level     = '0;
            victim_ptr     = '0;
            active_palette = '0;
            warmed         = 1'b0;
            mismatches     = 0;
            expected_replies.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            // check the result side first so a same-cycle transaction is not matched
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected result: hit %0d pal_index %0d",
                           i_out_mon.hit, i_out_mon.pal_index);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_out_mon.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, i_out_mon.hit);
                        mismatches++;
                    end
                    if (i_out_mon.pal_index !== want.pal_index) begin
                        $error("pal_index: expected %0d, actual %0d",
                               want.pal_index, i_out_mon.pal_index);
                        mismatches++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                predicted = cache_response(i_in_mon.cmd, i_in_mon.palette_id,
                                           i_in_mon.color, i_in_mon.fill_index);
                expected_replies = {expected_replies, predicted};
            end
            o_pending    <= expected_replies.size();
            o_fail_count <= mismatches;
        end
    end

endmodule

@@ bench/color_to_palette_index_cache_tb.sv @@
`timescale 1ns / 100ps

module color_to_palette_index_cache_tb;
    import cpic_pkg::*;

    localparam int RANDOM_ITEMS = 1330;
    localparam int TAIL_ITEMS   = 150;
    localparam int POOL_SIZE    = 40;
    localparam int QUIET_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending;
    int   items_sent;
    int   quiet_cycles;
    int   stall_left;

    logic [PAL_W-1:0]   palette;
    logic [COLOR_W-1:0] color_pool [POOL_SIZE];
    logic [COLOR_W-1:0] pick;
    int                 seg_left;
    int                 choice;

    cpic_in_if  in_ch();
    cpic_out_if out_ch();

    color_to_palette_index_cache dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    color_to_palette_index_cache_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver stalls in bursts of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b1;
            stall_left   <= 0;
        end else if (calm) begin
            out_ch.ready <= 1'b1;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 4);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic cmd, input logic [PAL_W-1:0] pal,
                             input logic [COLOR_W-1:0] col, input logic [IDX_W-1:0] fidx);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.palette_id <= pal;
        in_ch.color      <= col;
        in_ch.fill_index <= fidx;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic new_segment();
        choice = $urandom_range(0, 9);
        if (choice == 0) palette = '0;
        else if (choice == 1) palette = '1;
        else palette = $urandom();
        for (int k = 0; k < POOL_SIZE; k++) begin
            color_pool[k] = COLOR_W'($urandom());
        end
        seg_left = $urandom_range(60, 200);
        calm    <= (items_sent >= RANDOM_ITEMS - TAIL_ITEMS) || ($urandom_range(0, 4) == 0);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        calm             <= 1'b1;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_LOOKUP;
        in_ch.palette_id <= '0;
        in_ch.color      <= '0;
        in_ch.fill_index <= '0;
        items_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // palette zero on first use, fill without miss, duplicates, extremes
        send_item(CMD_LOOKUP, 32'h0, 24'h000000, 8'h00);
        send_item(CMD_FILL,   32'h0, 24'h000000, 8'h00);
        send_item(CMD_LOOKUP, 32'h0, 24'h000000, 8'h77);
        send_item(CMD_LOOKUP, 32'h0, 24'hFFFFFF, 8'hFF);
        send_item(CMD_FILL,   32'h0, 24'hFFFFFF, 8'hFF);
        send_item(CMD_LOOKUP, 32'h0, 24'hFFFFFF, 8'h00);
        send_item(CMD_FILL,   32'h0, 24'h000000, 8'h5A);
        send_item(CMD_LOOKUP, 32'h0, 24'h000000, 8'h00);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 24'h000000, 8'h00);
        send_item(CMD_FILL,   32'hFFFF_FFFF, 24'hA5A5A5, 8'hA5);
        send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 24'hA5A5A5, 8'h00);
        send_item(CMD_FILL,   32'h1234_5678, 24'h5A5A5A, 8'h3C);
        send_item(CMD_LOOKUP, 32'h1234_5678, 24'h5A5A5A, 8'h00);
        send_item(CMD_LOOKUP, 32'h1234_5678, 24'hA5A5A5, 8'h00);
        send_item(CMD_FILL,   32'h1234_5678, 24'hA5A5A5, 8'hC3);
        send_item(CMD_LOOKUP, 32'h1234_5678, 24'hA5A5A5, 8'h00);
        send_item(CMD_LOOKUP, 32'h0, 24'h5A5A5A, 8'h00);
        send_item(CMD_FILL,   32'h0, 24'h5A5A5A, 8'h81);
        send_item(CMD_LOOKUP, 32'h0, 24'h5A5A5A, 8'h00);
        drain_results();

        new_segment();
        while (items_sent < RANDOM_ITEMS) begin
            if (seg_left <= 0) new_segment();
            else if (items_sent >= RANDOM_ITEMS - TAIL_ITEMS) calm <= 1'b1;
            if (items_sent >= 700 && items_sent < 702) drain_results();
            pick   = color_pool[$urandom_range(0, POOL_SIZE - 1)];
            choice = $urandom_range(0, 99);
            if (choice < 80) begin
                // lookup, followed at random by a fill of the same color
                send_item(CMD_LOOKUP, palette, pick, IDX_W'($urandom()));
                seg_left--;
                if ($urandom_range(0, 1) == 0) begin
                    send_item(CMD_FILL, palette, pick, IDX_W'($urandom()));
                    seg_left--;
                end
            end else if (choice < 90) begin
                send_item(CMD_FILL, palette, pick, IDX_W'($urandom()));
                seg_left--;
            end else if (choice < 98) begin
                send_item(CMD_LOOKUP, palette, COLOR_W'($urandom()), IDX_W'($urandom()));
                seg_left--;
            end else if (choice < 99) begin
                send_item(CMD_FILL, palette, COLOR_W'($urandom()), IDX_W'($urandom()));
                seg_left--;
            end else begin
                // stray transaction on another palette flushes the cache
                send_item(1'($urandom()), $urandom(), COLOR_W'($urandom()),
                          IDX_W'($urandom()));
                seg_left--;
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
